// ===== design/sprs_pkg.sv =====
`timescale 1ns / 1ps

package sprs_pkg;

  // fixed field widths of the request and response
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = 13;

  // request operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND_FIRST,
    ST_FIND_LAST,
    ST_DONE
  } state_e;

  // search unit control from the sequencer
  typedef struct packed {
    logic start;
    logic strict;
  } srch_ctl_t;

  // search unit status to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } srch_sts_t;

endpackage

// ===== design/sprs_if.sv =====
`timescale 1ns / 1ps

// request channel
interface sprs_req_if;
  logic                           valid;
  logic                           ready;
  logic [sprs_pkg::FUNC_W-1:0]    func;
  logic [sprs_pkg::POS_W-1:0]     site_position;
  logic [sprs_pkg::POS_W-1:0]     query_left;
  logic [sprs_pkg::POS_W-1:0]     query_right;

  modport source (
    output valid, func, site_position, query_left, query_right,
    input  ready
  );
  modport sink (
    input  valid, func, site_position, query_left, query_right,
    output ready
  );
endinterface

// response channel
interface sprs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sprs_pkg::STATUS_W-1:0]  status;
  logic [sprs_pkg::IDX_W-1:0]     first_index;
  logic [sprs_pkg::IDX_W-1:0]     match_count;

  modport source (
    output valid, status, first_index, match_count,
    input  ready
  );
  modport sink (
    input  valid, status, first_index, match_count,
    output ready
  );
endinterface

// ===== design/sorted_position_range_search_core.sv =====
`timescale 1ns / 1ps

// clear and append: the sequencer goes from idle to the done state, then loads the response into the output register
// query: two binary searches run in turn, each of at most log2(TABLE_DEPTH) + 1 read/compare
//   steps, one table read and compare per cycle
// one request in flight; a finished response waits in the output register meanwhile
// reset clears the entry count and sequencer; table contents are not cleared

module sorted_position_range_search_core #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sprs_req_if.sink    req_i,
  sprs_rsp_if.source  rsp_o
);

  localparam int unsigned AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = sprs_pkg::IDX_W;

  sprs_pkg::state_e             state_q, state_d;
  sprs_pkg::srch_ctl_t          srch_ctl;
  sprs_pkg::srch_sts_t          srch_sts;
  logic [CW-1:0]                srch_lo, srch_hi, srch_res;
  logic [sprs_pkg::POS_W-1:0]   srch_bound;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [sprs_pkg::POS_W-1:0]   rdata;
  logic                         mem_we;

  logic [CW-1:0]                count_q;
  logic [sprs_pkg::POS_W-1:0]   right_q;
  logic [sprs_pkg::STATUS_W-1:0] res_status_q;
  logic [CW-1:0]                res_first_q, res_count_q;
  logic                         out_valid_q;
  logic [sprs_pkg::STATUS_W-1:0] out_status_q;
  logic [CW-1:0]                out_first_q, out_count_q;

  logic                         accept, full, rng_bad, out_load;
  logic                         is_clear, is_append, is_query;

  assign accept    = req_i.valid && req_i.ready;
  assign full      = count_q == CW'(TABLE_DEPTH);
  assign rng_bad   = req_i.query_right < req_i.query_left;
  assign is_clear  = req_i.func == sprs_pkg::FUNC_CLEAR;
  assign is_append = req_i.func == sprs_pkg::FUNC_APPEND;
  assign is_query  = req_i.func == sprs_pkg::FUNC_QUERY;
  assign out_load  = (state_q == sprs_pkg::ST_DONE) && (!out_valid_q || rsp_o.ready);

  // position table
  sprs_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (req_i.site_position),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // shared search unit
  sprs_bsearch #(.TABLE_DEPTH(TABLE_DEPTH)) u_bsearch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (srch_ctl),
    .lo_i      (srch_lo),
    .hi_i      (srch_hi),
    .bound_i   (srch_bound),
    .rdata_i   (rdata),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .sts_o     (srch_sts),
    .result_o  (srch_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sprs_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (is_query && !rng_bad) ? sprs_pkg::ST_FIND_FIRST : sprs_pkg::ST_DONE;
        end
      end
      sprs_pkg::ST_FIND_FIRST: begin
        if (srch_sts.done) begin
          state_d = sprs_pkg::ST_FIND_LAST;
        end
      end
      sprs_pkg::ST_FIND_LAST: begin
        if (srch_sts.done) begin
          state_d = sprs_pkg::ST_DONE;
        end
      end
      sprs_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = sprs_pkg::ST_IDLE;
        end
      end
      default: state_d = sprs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req_i.ready = 1'b0;
    mem_we      = 1'b0;
    srch_ctl    = '{start: 1'b0, strict: 1'b0};
    srch_lo     = '0;
    srch_hi     = count_q;
    srch_bound  = req_i.query_left;
    unique case (state_q)
      sprs_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        mem_we      = req_i.valid && is_append && !full;
        if (req_i.valid && is_query && !rng_bad) begin
          srch_ctl = '{start: 1'b1, strict: 1'b1};
        end
      end
      sprs_pkg::ST_FIND_FIRST: begin
        srch_lo    = srch_res;
        srch_bound = right_q;
        if (srch_sts.done) begin
          srch_ctl = '{start: 1'b1, strict: 1'b0};
        end
      end
      sprs_pkg::ST_FIND_LAST, sprs_pkg::ST_DONE: begin
        srch_ctl = '{start: 1'b0, strict: 1'b0};
      end
      default: srch_ctl = '{start: 1'b0, strict: 1'b0};
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sprs_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && is_clear) begin
        count_q <= '0;
      end else if (mem_we) begin
        count_q <= count_q + CW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result and request registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      right_q     <= req_i.query_right;
      res_first_q <= '0;
      res_count_q <= '0;
      priority if (is_append && full) begin
        res_status_q <= sprs_pkg::STATUS_FULL;
      end else if (is_query && rng_bad) begin
        res_status_q <= sprs_pkg::STATUS_EMPTY;
      end else begin
        res_status_q <= sprs_pkg::STATUS_OK;
      end
    end
    if (state_q == sprs_pkg::ST_FIND_FIRST && srch_sts.done) begin
      res_first_q <= srch_res;
    end
    if (state_q == sprs_pkg::ST_FIND_LAST && srch_sts.done) begin
      res_count_q <= srch_res - res_first_q;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_first_q  <= res_first_q;
      out_count_q  <= res_count_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.first_index = IdxW'(out_first_q);
  assign rsp_o.match_count = IdxW'(out_count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_clear) |=> (count_q == '0))
    else $error("clear did not empty the table");

  a_search_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (srch_sts.busy || srch_sts.done) |->
      (state_q == sprs_pkg::ST_FIND_FIRST || state_q == sprs_pkg::ST_FIND_LAST))
    else $error("search unit active outside a query");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == sprs_pkg::STATUS_EMPTY) |->
      (out_first_q == '0 && out_count_q == '0))
    else $error("empty range response carries nonzero fields");

  a_no_write_searching: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sprs_pkg::ST_IDLE) |-> !mem_we)
    else $error("table written outside idle");

endmodule

// ===== design/sprs_store.sv =====
`timescale 1ns / 1ps

module sprs_store #(
  parameter int unsigned TABLE_DEPTH = 4096,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [sprs_pkg::POS_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [sprs_pkg::POS_W-1:0]  rdata_o
);

  logic [sprs_pkg::POS_W-1:0] mem [TABLE_DEPTH];
  logic [sprs_pkg::POS_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sprs_bsearch.sv =====
`timescale 1ns / 1ps

module sprs_bsearch #(
  parameter int unsigned TABLE_DEPTH = 4096,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sprs_pkg::srch_ctl_t         ctl_i,
  input  logic [CW-1:0]               lo_i,
  input  logic [CW-1:0]               hi_i,
  input  logic [sprs_pkg::POS_W-1:0]  bound_i,
  input  logic [sprs_pkg::POS_W-1:0]  rdata_i,
  output logic                        rd_en_o,
  output logic [AW-1:0]               rd_addr_o,
  output sprs_pkg::srch_sts_t         sts_o,
  output logic [CW-1:0]               result_o
);

  logic [CW-1:0]               lo_q, hi_q, res_q;
  logic [AW-1:0]               mid_q;
  logic [sprs_pkg::POS_W-1:0]  bound_q;
  logic                        strict_q;
  logic                        active_q, done_q;
  logic                        go_right;
  logic [CW-1:0]               lo_n, hi_n;
  logic                        start_ok, step_more;

  // floor of the midpoint, always below the table depth
  function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
    logic [CW:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[AW:1];
  endfunction

  // shared compare against the bound, then narrow the window
  assign go_right  = (rdata_i < bound_q) || (!strict_q && (rdata_i == bound_q));
  assign lo_n      = go_right ? (CW'(mid_q) + CW'(1)) : lo_q;
  assign hi_n      = go_right ? hi_q : CW'(mid_q);
  assign start_ok  = lo_i < hi_i;
  assign step_more = lo_n < hi_n;

  // next read goes out in the same cycle as the compare
  assign rd_en_o   = (ctl_i.start && start_ok) || (!ctl_i.start && active_q && step_more);
  assign rd_addr_o = ctl_i.start ? mid_of(lo_i, hi_i) : mid_of(lo_n, hi_n);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        active_q <= start_ok;
        done_q   <= !start_ok;
      end else if (active_q && !step_more) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end
  end

  // window, midpoint and result
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      lo_q     <= lo_i;
      hi_q     <= hi_i;
      bound_q  <= bound_i;
      strict_q <= ctl_i.strict;
      mid_q    <= mid_of(lo_i, hi_i);
      res_q    <= lo_i;
    end else if (active_q) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_of(lo_n, hi_n);
      res_q <= lo_n;
    end
  end

  assign sts_o    = '{busy: active_q, done: done_q};
  assign result_o = res_q;

  // window stays non-empty while stepping
  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (lo_q < hi_q))
    else $error("search window empty while active");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> !ctl_i.start)
    else $error("search restarted while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !active_q)
    else $error("search done while still active");

endmodule

// ===== test/sorted_position_range_search_core_tb.sv =====
`timescale 1ns / 1ps

module sorted_position_range_search_core_tb;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned CLK_PERIOD  = 4;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned FUNC_W      = sprs_pkg::FUNC_W;
  localparam int unsigned POS_W       = sprs_pkg::POS_W;
  localparam int unsigned IDX_W       = sprs_pkg::IDX_W;
  // entries loaded by the large table test
  localparam int unsigned LOAD_DEPTH  = 512;
  // step that spreads the large table over most of the position range
  localparam logic [POS_W-1:0] LOAD_STEP = 32'h007F_FF88;
  localparam logic [POS_W-1:0] POS_MAX   = 32'hFFFF_FFFF;
  // unused operation code, the block answers it with an all-zero response
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    sprs_pkg::status_e    status;
    logic [IDX_W-1:0]     first_index;
    logic [IDX_W-1:0]     match_count;
  } site_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sprs_req_if req_if ();
  sprs_rsp_if rsp_if ();

  sorted_position_range_search_core #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow copy of the site table
  logic [POS_W-1:0] site_table [TABLE_DEPTH];
  int unsigned      site_count;

  site_result_t pending_results [$];
  int unsigned  fail_count;
  int unsigned  idle_pct = 31;
  int unsigned  rsp_hold_len;

  // run statistics
  int unsigned requests_sent;
  int unsigned queries_run;
  int unsigned empty_windows;
  int unsigned reversed_windows;
  int unsigned full_rejects;
  int unsigned deepest_table;

  // first index in [lo, hi) whose entry fails the bound test, or hi if none does
  function automatic int unsigned search_edge(int unsigned lo, int unsigned hi,
                                              logic [POS_W-1:0] bound, bit strict);
    int unsigned mid;
    bit          go_up;
    while (lo < hi) begin
      mid   = (lo + hi) / 2;
      go_up = strict ? (site_table[mid] < bound) : (site_table[mid] <= bound);
      if (go_up) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // update the shadow table and work out the response of one request
  function automatic site_result_t apply_to_table(logic [FUNC_W-1:0] func,
                                                  logic [POS_W-1:0] pos,
                                                  logic [POS_W-1:0] left,
                                                  logic [POS_W-1:0] right);
    site_result_t r;
    int unsigned  first;
    int unsigned  last;
    r.status      = sprs_pkg::STATUS_OK;
    r.first_index = '0;
    r.match_count = '0;
    case (func)
      sprs_pkg::FUNC_CLEAR: site_count = 0;
      sprs_pkg::FUNC_APPEND: begin
        if (site_count >= TABLE_DEPTH) begin
          r.status = sprs_pkg::STATUS_FULL;
          full_rejects++;
        end else begin
          site_table[site_count] = pos;
          site_count++;
        end
      end
      sprs_pkg::FUNC_QUERY: begin
        queries_run++;
        if (right < left) begin
          r.status = sprs_pkg::STATUS_EMPTY;
          reversed_windows++;
        end else begin
          first = search_edge(0, site_count, left, 1'b1);
          last  = search_edge(first, site_count, right, 1'b0);
          r.first_index = IDX_W'(first);
          r.match_count = IDX_W'(last - first);
          if (last == first) empty_windows++;
          if (site_count > deepest_table) deepest_table = site_count;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // offer one request, with a random gap first, and log the expected response
  task automatic send_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                              logic [POS_W-1:0] left, logic [POS_W-1:0] right);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.func          <= func;
    req_if.site_position <= pos;
    req_if.query_left    <= left;
    req_if.query_right   <= right;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(apply_to_table(func, pos, left, right));
    if (func != FUNC_UNUSED) requests_sent++;
  endtask

  // stop offering and wait until every response is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_append(logic [POS_W-1:0] pos);
    send_request(sprs_pkg::FUNC_APPEND, pos, $urandom, $urandom);
  endtask

  task automatic send_query(logic [POS_W-1:0] left, logic [POS_W-1:0] right);
    send_request(sprs_pkg::FUNC_QUERY, $urandom, left, right);
  endtask

  // bound at or near a stored position, at the edges of the range, or random
  function automatic logic [POS_W-1:0] pick_bound();
    int unsigned      mode;
    logic [POS_W-1:0] v;
    mode = $urandom_range(0, 99);
    v    = $urandom;
    if (site_count != 0 && mode < 55) begin
      v = site_table[$urandom_range(0, site_count - 1)];
      if (mode >= 40) v = ($urandom_range(0, 1) == 0) ? v + 1 : v - 1;
    end else if (mode < 70) v = $urandom;
    else if (mode < 80) v = '0;
    else if (mode < 90) v = POS_MAX;
    else v = $urandom >> $urandom_range(0, 31);
    return v;
  endfunction

  task automatic send_random_query();
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] t;
    bit               reversed;
    reversed = ($urandom_range(0, 9) == 0);
    left     = pick_bound();
    if ($urandom_range(0, 1) == 0) begin
      right = pick_bound();
    end else begin
      span  = $urandom >> $urandom_range(0, 31);
      right = (left > POS_MAX - span) ? POS_MAX : left + span;
    end
    if (reversed ? (right > left) : (right < left)) begin
      t     = left;
      left  = right;
      right = t;
    end
    send_query(left, right);
  endtask

  // clear (mostly, and always when over 2500 entries), load a table, then query it
  task automatic run_session();
    int unsigned      kind;
    int unsigned      n_appends;
    int unsigned      n_queries;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] gap_cap;
    logic [POS_W-1:0] step;
    bit               scrambled;
    if (site_count > 2500 || $urandom_range(0, 3) != 0)
      send_request(sprs_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom);
    kind      = $urandom_range(0, 99);
    n_appends = (kind < 70) ? $urandom_range(0, 16) :
                (kind < 95) ? $urandom_range(17, 128) : $urandom_range(129, 600);
    scrambled = ($urandom_range(0, 9) == 0);
    pos       = ($urandom_range(0, 2) == 0) ? '0 : $urandom >> $urandom_range(0, 31);
    gap_cap   = POS_MAX >> $urandom_range(1, 31);
    for (int unsigned i = 0; i < n_appends; i++) begin
      if (scrambled) begin
        send_append($urandom);
      end else begin
        send_append(pos);
        step = ($urandom_range(0, 4) == 0) ? '0 : ($urandom % (gap_cap + 1));
        pos  = (pos > POS_MAX - step) ? POS_MAX : pos + step;
      end
      if ($urandom_range(0, 24) == 0)
        send_request(FUNC_UNUSED, $urandom, $urandom, $urandom);
    end
    n_queries = $urandom_range(1, 12);
    repeat (n_queries) send_random_query();
  endtask

  task automatic test_empty_table_and_unused_code();
    send_query('0, POS_MAX);
    send_request(FUNC_UNUSED, POS_MAX, POS_MAX, POS_MAX);
    send_request(sprs_pkg::FUNC_CLEAR, POS_MAX, POS_MAX, POS_MAX);
    send_query(POS_MAX, '0);
    drain_results();
  endtask

  task automatic test_small_table();
    send_append('0);
    send_append(32'd5);
    send_append(32'd5);
    send_append(32'd10);
    send_append(POS_MAX);
    send_query('0, POS_MAX);
    send_query(32'd5, 32'd5);
    send_query(32'd6, 32'd9);
    send_query(POS_MAX, POS_MAX);
    send_query(32'd10, 32'd9);
    send_query('0, '0);
    send_query(32'd11, 32'hFFFF_FFFE);
    // out of order append, searches still run as defined
    send_append(32'd3);
    send_query(32'd3, 32'd4);
    send_query('0, 32'd5);
    send_request(FUNC_UNUSED, '0, '0, '0);
    drain_results();
  endtask

  // response side stalls while requests keep coming, then a full drain
  task automatic test_response_backpressure();
    rsp_hold_len = 300;
    repeat (12) send_random_query();
    drain_results();
  endtask

  // evenly spread large table, then queries over it
  task automatic test_large_table();
    send_request(sprs_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom);
    for (int unsigned i = 0; i < LOAD_DEPTH; i++) send_append(i * LOAD_STEP);
    send_append('0);
    send_append(POS_MAX);
    send_query('0, POS_MAX);
    send_query(LOAD_STEP * 100, LOAD_STEP * 199);
    send_query(LOAD_STEP * (LOAD_DEPTH - 1) + 1, POS_MAX);
    send_query(32'd1, LOAD_STEP);
    send_query(LOAD_STEP * 7, LOAD_STEP * 6);
    repeat (10) send_random_query();
    drain_results();
  endtask

  // back to back traffic with no idling on either side
  task automatic test_no_idle_burst();
    int unsigned start;
    idle_pct = 0;
    start    = requests_sent;
    while (requests_sent - start < 200) run_session();
    drain_results();
    idle_pct = 31;
  endtask

  task automatic test_random_sessions(int unsigned goal);
    int unsigned start;
    start = requests_sent;
    while (requests_sent - start < goal) run_session();
    drain_results();
  endtask

  // response ready, with random stalls and a commanded long hold
  initial begin : drive_rsp_ready
    int unsigned hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_len != 0) begin
        hold_left    = rsp_hold_len;
        rsp_hold_len = 0;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // compare each response with the oldest expectation
  always @(posedge clk_i) begin : check_responses
    site_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("response with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.first_index !== want.first_index) begin
          $error("first_index: expected %0d, got %0d", want.first_index,
                 rsp_if.first_index);
          fail_count++;
        end
        if (rsp_if.match_count !== want.match_count) begin
          $error("match_count: expected %0d, got %0d", want.match_count,
                 rsp_if.match_count);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("[sorted_position_range_search_core] ERROR");
    $finish;
  end

  initial begin : main_sequence
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.func          <= sprs_pkg::FUNC_CLEAR;
    req_if.site_position <= '0;
    req_if.query_left    <= '0;
    req_if.query_right   <= '0;
    site_count   = 0;
    fail_count   = 0;
    rsp_hold_len = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table_and_unused_code();
    test_small_table();
    test_response_backpressure();
    test_large_table();
    test_no_idle_burst();
    test_random_sessions(600);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d requests: %0d queries, %0d reversed, %0d with no match",
             requests_sent, queries_run, reversed_windows, empty_windows);
    $display("table full rejects %0d, largest table searched %0d entries",
             full_rejects, deepest_table);
    if (fail_count == 0) begin
      $display("[sorted_position_range_search_core] OK");
    end else begin
      $display("[sorted_position_range_search_core] ERROR");
    end
    $finish;
  end

endmodule
